// ----- design/adfs_pkg.sv -----
// Shared types and constants for the adjacency matrix depth-first search engine.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package adfs_pkg;

    localparam int MODE_W   = 3;
    localparam int VTX_W    = 4;
    localparam int WGT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int DEG_W    = 4;
    localparam int ETOT_W   = 7;
    localparam int VCNT_W   = 5;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_QUERY  = 3'd2,
        MODE_DEGREE = 3'd3,
        MODE_SEARCH = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ROW_A,
        ROW_B,
        ROW_TOP
    } row_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load_op;
        logic     rd_row;
        row_sel_t rd_sel;
        logic     rd_wt;
        logic     wr_wt;
        logic     wr_row;
        logic     wr_b;
        logic     wr_set;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     srch_init;
        logic     push;
        logic     pop;
        logic     load_top;
        logic     emit;
        status_t  emit_status;
        logic     emit_wt;
        logic     emit_deg;
        logic     emit_vtx;
        logic     emit_last;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              a_ok;
        logic              b_ok;
        logic              same;
        logic              w_zero;
        logic              present;
        logic              found;
        logic              depth_last;
        logic              depth_full;
        logic              out_free;
    } dp_stat_t;

endpackage

// ----- design/adfs_if.sv -----
// Handshake channels of the engine: request items, result items and the setup write.
// Depends on adfs_pkg for the field widths.
`timescale 1ns / 1ps

interface adfs_req_if import adfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [VTX_W-1:0]  first_vertex;
    logic [VTX_W-1:0]  second_vertex;
    logic [WGT_W-1:0]  edge_weight;

    modport source (output valid, mode, first_vertex, second_vertex, edge_weight,
                    input ready);
    modport sink   (input valid, mode, first_vertex, second_vertex, edge_weight,
                    output ready);
endinterface

interface adfs_rsp_if import adfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WGT_W-1:0]    weight_read;
    logic [DEG_W-1:0]    degree_read;
    logic [ETOT_W-1:0]   edge_total;
    logic [VTX_W-1:0]    visited_vertex;
    logic                last_result;

    modport source (output valid, status, weight_read, degree_read, edge_total,
                    visited_vertex, last_result, input ready);
    modport sink   (input valid, status, weight_read, degree_read, edge_total,
                    visited_vertex, last_result, output ready);
endinterface

interface adfs_cfg_if import adfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VCNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

// ----- design/adjacency_matrix_dfs_engine.sv -----
// Edge ops: the result loads in the decode step (bad vertex or mode), the check step (query,
// degree, no change, self loop, zero weight) or the pair step (insert, remove), waiting while
// an untaken result is held; the next item is taken when the engine is back idle. Search: a
// vertex reached costs a row read and a scan, a step back a scan, a stack pop and a row read,
// set by the single row memory read port. Reset (async, active low) empties the graph at once
// via per-row valid flags, no clearing pass; vertex_count returns to 16, edge count to zero.
`timescale 1ns / 1ps

module adjacency_matrix_dfs_engine import adfs_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    adfs_req_if.sink   request,
    adfs_rsp_if.source response,
    adfs_cfg_if.sink   setup
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_ready;

    assign request.ready = req_ready;
    assign setup.ready   = 1'b1;

    adfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    adfs_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .req_mode           (request.mode),
        .req_first_vertex   (request.first_vertex),
        .req_second_vertex  (request.second_vertex),
        .req_edge_weight    (request.edge_weight),
        .cfg_valid          (setup.valid),
        .cfg_vertex_count   (setup.vertex_count),
        .rsp_valid          (response.valid),
        .rsp_ready          (response.ready),
        .rsp_status         (response.status),
        .rsp_weight_read    (response.weight_read),
        .rsp_degree_read    (response.degree_read),
        .rsp_edge_total     (response.edge_total),
        .rsp_visited_vertex (response.visited_vertex),
        .rsp_last_result    (response.last_result)
    );

    // A result is only loaded into a free or draining result register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over an untaken result");

    // The stack never grows past one entry per vertex
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.depth_full)
        else $error("search stack overflow");

    // One item at a time: the engine leaves idle after taking an item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("item taken while another is in progress");

    // Only search results come without the last mark, and they always report success
    a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && !response.last_result) |-> (response.status == ST_DONE))
        else $error("intermediate result with a failure status");

endmodule

// ----- design/adfs_datapath.sv -----
// Datapath: adjacency row memory, weight memory, search stack, visited flags,
// edge counter and the result register. Depends on adfs_pkg.
`timescale 1ns / 1ps

module adfs_datapath import adfs_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [MODE_W-1:0]   req_mode,
    input  logic [VTX_W-1:0]    req_first_vertex,
    input  logic [VTX_W-1:0]    req_second_vertex,
    input  logic [WGT_W-1:0]    req_edge_weight,
    input  logic                cfg_valid,
    input  logic [VCNT_W-1:0]   cfg_vertex_count,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [WGT_W-1:0]    rsp_weight_read,
    output logic [DEG_W-1:0]    rsp_degree_read,
    output logic [ETOT_W-1:0]   rsp_edge_total,
    output logic [VTX_W-1:0]    rsp_visited_vertex,
    output logic                rsp_last_result
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int WA = 2 * VW;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Operand registers
    logic [MODE_W-1:0]      mode_reg;
    logic [VTX_W-1:0]       a_reg;
    logic [VTX_W-1:0]       b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [VCNT_W-1:0]      vcount_reg;

    logic [VCNT_W-1:0]       active;
    logic [MAX_VERTICES-1:0] act_mask;
    logic [VW-1:0]           a_idx;
    logic [VW-1:0]           b_idx;

    // Adjacency rows, one bit per neighbour; a row never written reads empty
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_ok_reg;
    logic [MAX_VERTICES-1:0] row_rd_reg;
    logic                    row_rd_ok_reg;
    logic [MAX_VERTICES-1:0] row;
    logic [VW-1:0]           rd_addr;
    logic [VW-1:0]           wr_addr;
    logic [MAX_VERTICES-1:0] bit_mask;
    logic [MAX_VERTICES-1:0] wr_data;

    // Weights, one entry per unordered vertex pair
    logic [WEIGHT_BITS-1:0] wt_mem [2**WA];
    logic [WEIGHT_BITS-1:0] wt_rd_reg;
    logic [WA-1:0]          wt_addr;

    // Search state
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VW-1:0]           stk_mem [MAX_VERTICES];
    logic [VW-1:0]           stk_rd_reg;
    logic [DW-1:0]           depth_reg;
    logic [VW-1:0]           top_reg;
    logic [VW-1:0]           pend_reg;
    logic [MAX_VERTICES-1:0] cand;
    logic                    found;
    logic [VW-1:0]           cand_idx;
    logic [VW-1:0]           stk_wr_addr;
    logic [VW-1:0]           stk_wr_data;

    logic [EW-1:0] edge_cnt_reg;
    logic [CW-1:0] degree;
    logic          out_free;

    // Result register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WGT_W-1:0]    wt_out_reg;
    logic [DEG_W-1:0]    deg_out_reg;
    logic [ETOT_W-1:0]   etot_reg;
    logic [VTX_W-1:0]    vtx_reg;
    logic                last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            mode_reg <= req_mode;
            a_reg    <= req_first_vertex;
            b_reg    <= req_second_vertex;
            w_reg    <= WEIGHT_BITS'(req_edge_weight);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= VCNT_RESET;
        else if (cfg_valid)
            vcount_reg <= cfg_vertex_count;
    end

    always_comb
    begin
        if (int'(vcount_reg) < MAX_VERTICES)
            active = vcount_reg;
        else
            active = VCNT_W'(MAX_VERTICES);
        for (int i = 0; i < MAX_VERTICES; i++)
            act_mask[i] = (i < int'(active));
    end

    assign a_idx = VW'(a_reg);
    assign b_idx = VW'(b_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            ROW_A:   rd_addr = a_idx;
            ROW_B:   rd_addr = b_idx;
            ROW_TOP: rd_addr = top_reg;
            default: rd_addr = a_idx;
        endcase
    end

    assign row      = row_rd_ok_reg ? row_rd_reg : '0;
    assign wr_addr  = cmd.wr_b ? b_idx : a_idx;
    assign bit_mask = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << (cmd.wr_b ? a_idx : b_idx);
    assign wr_data  = cmd.wr_set ? (row | bit_mask) : (row & ~bit_mask);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_row)
            adj_mem[wr_addr] <= wr_data;
        if (cmd.rd_row)
            row_rd_reg <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg    <= '0;
            row_rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_row)
                row_rd_ok_reg <= row_ok_reg[rd_addr];
            if (cmd.wr_row)
                row_ok_reg[wr_addr] <= 1'b1;
        end
    end

    // Smaller index first, so both orientations share one entry
    assign wt_addr = (a_idx < b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_wt)
            wt_mem[wt_addr] <= w_reg;
        if (cmd.rd_wt)
            wt_rd_reg <= wt_mem[wt_addr];
    end

    always_comb
    begin
        degree = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
            degree = degree + CW'(row[i]);
    end

    // Lowest unvisited neighbour within the active vertex range
    assign cand = row & ~visited_reg & act_mask;

    always_comb
    begin
        found    = 1'b0;
        cand_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found    = 1'b1;
                cand_idx = VW'(i);
            end
        end
    end

    assign stk_wr_addr = cmd.srch_init ? '0 : VW'(depth_reg);
    assign stk_wr_data = cmd.srch_init ? a_idx : cand_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.srch_init || cmd.push)
            stk_mem[stk_wr_addr] <= stk_wr_data;
        if (cmd.pop)
            stk_rd_reg <= stk_mem[VW'(depth_reg - DW'(2))];
        if (cmd.srch_init)
        begin
            top_reg  <= a_idx;
            pend_reg <= a_idx;
        end
        else if (cmd.push)
        begin
            top_reg  <= cand_idx;
            pend_reg <= cand_idx;
        end
        else if (cmd.load_top)
            top_reg <= stk_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            depth_reg    <= '0;
            edge_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.srch_init)
            begin
                visited_reg <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_idx;
                depth_reg   <= DW'(1);
            end
            else if (cmd.push)
            begin
                visited_reg[cand_idx] <= 1'b1;
                depth_reg             <= depth_reg + DW'(1);
            end
            else if (cmd.pop)
                depth_reg <= depth_reg - DW'(1);

            if (cmd.cnt_inc)
                edge_cnt_reg <= edge_cnt_reg + EW'(1);
            else if (cmd.cnt_dec)
                edge_cnt_reg <= edge_cnt_reg - EW'(1);
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= cmd.emit_status;
            wt_out_reg  <= cmd.emit_wt ? WGT_W'(wt_rd_reg) : '0;
            deg_out_reg <= cmd.emit_deg ? DEG_W'(degree) : '0;
            etot_reg    <= ETOT_W'(edge_cnt_reg);
            vtx_reg     <= cmd.emit_vtx ? VTX_W'(pend_reg) : '0;
            last_reg    <= cmd.emit_last;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign rsp_status         = status_reg;
    assign rsp_weight_read    = wt_out_reg;
    assign rsp_degree_read    = deg_out_reg;
    assign rsp_edge_total     = etot_reg;
    assign rsp_visited_vertex = vtx_reg;
    assign rsp_last_result    = last_reg;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.a_ok       = VCNT_W'(a_reg) < active;
        stat.b_ok       = VCNT_W'(b_reg) < active;
        stat.same       = (a_reg == b_reg);
        stat.w_zero     = (w_reg == '0);
        stat.present    = row[b_idx];
        stat.found      = found;
        stat.depth_last = (depth_reg == DW'(1));
        stat.depth_full = (depth_reg == DW'(MAX_VERTICES));
        stat.out_free   = out_free;
    end

endmodule

// ----- design/adfs_ctrl.sv -----
// Controller: sequences each request item through decode, memory access,
// update and result steps, and walks the depth-first search. Depends on adfs_pkg.
`timescale 1ns / 1ps

module adfs_ctrl import adfs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_PAIR,
        S_SCAN_RD,
        S_SCAN,
        S_POP,
        S_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   bad_op;

    always_comb
    begin
        unique case (stat.mode) inside
            MODE_INSERT, MODE_REMOVE, MODE_QUERY: bad_op = !(stat.a_ok && stat.b_ok);
            MODE_DEGREE, MODE_SEARCH:             bad_op = !stat.a_ok;
            default:                              bad_op = 1'b1;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (bad_op)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_INVALID;
                        cmd.emit_last   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.mode == MODE_SEARCH)
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.rd_row = 1'b1;
                    cmd.rd_sel = ROW_A;
                    cmd.rd_wt  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.same || stat.w_zero || stat.present)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = (stat.same || stat.w_zero) ?
                                                  ST_INVALID : ST_NO_CHANGE;
                                cmd.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.wr_wt   = 1'b1;
                            cmd.wr_row  = 1'b1;
                            cmd.wr_set  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.rd_row  = 1'b1;
                            cmd.rd_sel  = ROW_B;
                            state_next  = S_PAIR;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!stat.present)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_NO_CHANGE;
                                cmd.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.wr_row  = 1'b1;
                            cmd.cnt_dec = 1'b1;
                            cmd.rd_row  = 1'b1;
                            cmd.rd_sel  = ROW_B;
                            state_next  = S_PAIR;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.present ? ST_DONE : ST_NO_CHANGE;
                            cmd.emit_wt     = stat.present;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_DONE;
                            cmd.emit_deg    = 1'b1;
                            cmd.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_PAIR:
            begin
                // Mirror the change into the second endpoint's row
                if (stat.out_free)
                begin
                    cmd.wr_row      = 1'b1;
                    cmd.wr_b        = 1'b1;
                    cmd.wr_set      = (stat.mode == MODE_INSERT);
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DONE;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_row = 1'b1;
                cmd.rd_sel = ROW_TOP;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.found && !stat.depth_full)
                begin
                    // Release the held vertex; the new one is held until the next step
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_DONE;
                        cmd.emit_vtx    = 1'b1;
                        cmd.push        = 1'b1;
                        state_next      = S_SCAN_RD;
                    end
                end
                else if (stat.depth_last)
                    state_next = S_FINAL;
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_DONE;
                    cmd.emit_vtx    = 1'b1;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
